FILE: hw/rtl/overwriting_log_ring_buffer_macros.svh
// ----------------------------------------------------------------------------
// Log ring buffer assertion macros
// Clocked assertion shorthands used by the ring buffer RTL.
// ----------------------------------------------------------------------------
`ifndef OVERWRITING_LOG_RING_BUFFER_MACROS_SVH
`define OVERWRITING_LOG_RING_BUFFER_MACROS_SVH

// Checked only while out of reset.
`define OLRB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define OLRB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: hw/rtl/olrb_pkg.sv
// ----------------------------------------------------------------------------
// Log ring buffer package
// Payload types, command codes and fixed constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package olrb_pkg;

  localparam int unsigned CHAN_COUNTED = 4;
  localparam int unsigned CHAN_IDX_W   = $clog2(CHAN_COUNTED);
  localparam int unsigned THRESH_W     = 7;
  localparam int unsigned FILL_W       = 7;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 7'd48;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_READ  = 1'b1
  } cmd_e;

  // Stored entry, 61 bits, time in the low bits.
  typedef struct packed {
    logic [7:0]  flags;
    logic [15:0] value;
    logic [1:0]  kind;
    logic [2:0]  channel;
    logic [31:0] time_ms;
  } entry_t;

  typedef struct packed {
    cmd_e        command;
    logic [31:0] entry_time;
    logic [2:0]  entry_channel;
    logic [1:0]  entry_type;
    logic [15:0] entry_value;
    logic [7:0]  entry_flags;
  } in_data_t;

  typedef struct packed {
    logic        read_valid;
    logic [31:0] out_time;
    logic [2:0]  out_channel;
    logic [1:0]  out_type;
    logic [15:0] out_value;
    logic [7:0]  out_flags;
    logic [FILL_W-1:0] fill_level;
    logic [31:0] writes_total;
    logic [31:0] overwrites_total;
    logic [31:0] channel_tally;
    logic        export_due;
  } out_data_t;

  // Status carried alongside the registered store read.
  typedef struct packed {
    logic              read_valid;
    logic [FILL_W-1:0] fill_level;
    logic [31:0]       writes_total;
    logic [31:0]       overwrites_total;
    logic [31:0]       channel_tally;
    logic              export_due;
  } stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/olrb_if.sv
// ----------------------------------------------------------------------------
// Log ring buffer channel interfaces
// Valid/ready channels for commands, results and the threshold register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface olrb_in_if;
  logic              valid;
  logic              ready;
  olrb_pkg::in_data_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface olrb_out_if;
  logic               valid;
  logic               ready;
  olrb_pkg::out_data_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface olrb_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [olrb_pkg::THRESH_W-1:0]     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/overwriting_log_ring_buffer.sv
// ----------------------------------------------------------------------------
// Overwriting log ring buffer
// Circular log store that drops the oldest entry when full, with counters.
// ----------------------------------------------------------------------------
// One command transaction is taken per cycle unless the middle stage is full
// behind a stalled output. On acceptance pointers and counters update and the
// store is read at the tail (registered read port) into the middle stage,
// which then loads the output register. A stalled output still lets one more
// command in, held in the middle stage. The store has no reset; the threshold
// register resets to 48 and may be written whenever no command is in flight.
`timescale 1ns / 1ps
`default_nettype none
`include "overwriting_log_ring_buffer_macros.svh"

module overwriting_log_ring_buffer #(
  parameter int unsigned RING_DEPTH = 64
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  olrb_in_if.sink          in_i,
  olrb_out_if.source       out_o,
  olrb_cfg_if.sink         cfg_i
);

  localparam int unsigned PW   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CW   = $clog2(RING_DEPTH + 1);
  localparam int unsigned CMPW = (CW > olrb_pkg::THRESH_W) ? CW : olrb_pkg::THRESH_W;
  localparam logic [PW-1:0] LAST_SLOT = PW'(RING_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(RING_DEPTH);

  function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] idx);
    next_slot = (idx == LAST_SLOT) ? '0 : idx + PW'(1);
  endfunction

  // Pointers, counters, threshold
  logic [PW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;
  logic [31:0]   writes_q, writes_d, ovw_q, ovw_d;
  logic [31:0]   chan_cnt_q [olrb_pkg::CHAN_COUNTED];
  logic [31:0]   chan_cnt_d [olrb_pkg::CHAN_COUNTED];
  logic [olrb_pkg::THRESH_W-1:0] thr_q;

  // Store
  olrb_pkg::entry_t mem [RING_DEPTH];
  olrb_pkg::entry_t rdata_q;
  olrb_pkg::entry_t wr_entry;

  // Pipeline
  logic               s1_valid_q, s1_valid_d;
  olrb_pkg::stat_t    s1_q, s1_d;
  logic               out_valid_q, out_valid_d;
  olrb_pkg::out_data_t out_q;

  logic accept, s1_adv, is_write, is_read, chan_ok;
  logic [olrb_pkg::CHAN_IDX_W-1:0] chan_idx;

  assign s1_adv     = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign accept     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign is_write = accept && (in_i.data.command == olrb_pkg::CMD_WRITE);
  assign is_read  = accept && (in_i.data.command == olrb_pkg::CMD_READ) && (count_q != '0);
  assign chan_ok  = in_i.data.entry_channel < 3'(olrb_pkg::CHAN_COUNTED);
  assign chan_idx = in_i.data.entry_channel[olrb_pkg::CHAN_IDX_W-1:0];

  assign wr_entry.flags   = in_i.data.entry_flags;
  assign wr_entry.value   = in_i.data.entry_value;
  assign wr_entry.kind    = in_i.data.entry_type;
  assign wr_entry.channel = in_i.data.entry_channel;
  assign wr_entry.time_ms = in_i.data.entry_time;

  // State update for the accepted command
  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    writes_d = writes_q;
    ovw_d    = ovw_q;
    for (int i = 0; i < olrb_pkg::CHAN_COUNTED; i++) begin
      chan_cnt_d[i] = chan_cnt_q[i];
    end
    if (is_write) begin
      head_d   = next_slot(head_q);
      writes_d = writes_q + 32'd1;
      if (count_q == FULL_CNT) begin
        // full: drop the oldest
        tail_d = next_slot(tail_q);
        ovw_d  = ovw_q + 32'd1;
      end else begin
        count_d = count_q + CW'(1);
      end
      if (chan_ok) begin
        chan_cnt_d[chan_idx] = chan_cnt_q[chan_idx] + 32'd1;
      end
    end else if (is_read) begin
      tail_d  = next_slot(tail_q);
      count_d = count_q - CW'(1);
    end
  end

  always_comb begin
    s1_d.read_valid       = is_read;
    s1_d.fill_level       = olrb_pkg::FILL_W'(count_d);
    s1_d.writes_total     = writes_d;
    s1_d.overwrites_total = ovw_d;
    s1_d.channel_tally    = chan_ok ? chan_cnt_d[chan_idx] : 32'd0;
    s1_d.export_due       = CMPW'(count_d) >= CMPW'(thr_q);
  end

  always_comb begin
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
    out_valid_d = s1_adv ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      writes_q    <= '0;
      ovw_q       <= '0;
      thr_q       <= olrb_pkg::THRESH_RESET;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < olrb_pkg::CHAN_COUNTED; i++) begin
        chan_cnt_q[i] <= '0;
      end
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      writes_q    <= writes_d;
      ovw_q       <= ovw_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      for (int i = 0; i < olrb_pkg::CHAN_COUNTED; i++) begin
        chan_cnt_q[i] <= chan_cnt_d[i];
      end
      if (cfg_i.valid && cfg_i.ready) begin
        thr_q <= cfg_i.data;
      end
    end
  end

  // Store write at head, registered read at tail
  always_ff @(posedge clk_i) begin
    if (is_write) begin
      mem[head_q] <= wr_entry;
    end
    if (accept) begin
      rdata_q <= mem[tail_q];
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
    if (s1_adv && s1_valid_q) begin
      out_q.read_valid       <= s1_q.read_valid;
      out_q.out_time         <= s1_q.read_valid ? rdata_q.time_ms : '0;
      out_q.out_channel      <= s1_q.read_valid ? rdata_q.channel : '0;
      out_q.out_type         <= s1_q.read_valid ? rdata_q.kind    : '0;
      out_q.out_value        <= s1_q.read_valid ? rdata_q.value   : '0;
      out_q.out_flags        <= s1_q.read_valid ? rdata_q.flags   : '0;
      out_q.fill_level       <= s1_q.fill_level;
      out_q.writes_total     <= s1_q.writes_total;
      out_q.overwrites_total <= s1_q.overwrites_total;
      out_q.channel_tally    <= s1_q.channel_tally;
      out_q.export_due       <= s1_q.export_due;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // Assertions
  `OLRB_ASSERT_ALWAYS(a_count_bound, count_q <= FULL_CNT, "fill count above ring depth")
  `OLRB_ASSERT(a_ptr_meet, (head_q == tail_q) |-> (count_q == '0 || count_q == FULL_CNT), "pointers meet with partial fill")
  `OLRB_ASSERT(a_ovw_full, (ovw_q != $past(ovw_q)) |-> ($past(count_q) == FULL_CNT), "overwrite counted while not full")
  `OLRB_ASSERT(a_stage_hold, (s1_valid_q && !s1_adv) |=> s1_valid_q, "middle stage lost a held result")

endmodule

`default_nettype wire
